FILE: design/imu_complementary_tilt_filter_top_assert.svh
// ----------------------------------------------------------------------------
// imu complementary tilt filter assertion macros
// shared property forms, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef IMU_COMPLEMENTARY_TILT_FILTER_TOP_ASSERT_SVH
`define IMU_COMPLEMENTARY_TILT_FILTER_TOP_ASSERT_SVH

// same-cycle implication
`define ICTF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ictf assertion failed");

// next-cycle implication
`define ICTF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ictf assertion failed");

`endif

FILE: design/ictf_pkg.sv
// ----------------------------------------------------------------------------
// ictf_pkg
// types, constants and helper functions of the imu complementary tilt filter
// ----------------------------------------------------------------------------
package ictf_pkg;

  localparam int SAMP_W           = 16;
  localparam int TS_W             = 64;
  localparam int ANG_W            = 24;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 16;
  localparam int CORDIC_STEPS_DEF = 20;
  localparam int CIN_W            = 26;
  localparam int CORD_W           = 28;
  localparam int Z_W              = 25;
  localparam int SAT_W            = 44;

  localparam logic signed [ANG_W-1:0] PI_Q20    = 24'sd3294199;
  localparam logic [CFG_DATA_W-1:0]   BLEND_RST = 16'd64225;
  localparam logic [CFG_DATA_W-1:0]   TPS_RST   = 16'd1000;

  localparam logic FUNC_GYRO  = 1'b0;
  localparam logic FUNC_ACCEL = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLEND = 1'b0,
    REG_TPS   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                     func;
    logic signed [SAMP_W-1:0] sample_x;
    logic signed [SAMP_W-1:0] sample_y;
    logic signed [SAMP_W-1:0] sample_z;
    logic [TS_W-1:0]          timestamp;
  } in_item_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] angle_x;
    logic signed [ANG_W-1:0] angle_y;
    logic signed [ANG_W-1:0] angle_z;
  } out_item_t;

  // arctangent of 2^-i in q3.20
  function automatic logic signed [Z_W-1:0] atan_entry(input logic [5:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      6'd0:  v = 25'sd823550;
      6'd1:  v = 25'sd486170;
      6'd2:  v = 25'sd256879;
      6'd3:  v = 25'sd130396;
      6'd4:  v = 25'sd65451;
      6'd5:  v = 25'sd32757;
      6'd6:  v = 25'sd16383;
      6'd7:  v = 25'sd8192;
      6'd8:  v = 25'sd4096;
      6'd9:  v = 25'sd2048;
      6'd10: v = 25'sd1024;
      6'd11: v = 25'sd512;
      6'd12: v = 25'sd256;
      6'd13: v = 25'sd128;
      6'd14: v = 25'sd64;
      6'd15: v = 25'sd32;
      6'd16: v = 25'sd16;
      6'd17: v = 25'sd8;
      6'd18: v = 25'sd4;
      6'd19: v = 25'sd2;
      6'd20: v = 25'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [ANG_W-1:0] sat_ang(input logic signed [SAT_W-1:0] v);
    logic signed [ANG_W-1:0] r;
    if (v > 44'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -44'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[ANG_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: design/ictf_div.sv
// ----------------------------------------------------------------------------
// ictf_div
// restoring divider, 64-bit dividend by 16-bit divisor, one bit per cycle
// ----------------------------------------------------------------------------
module ictf_div import ictf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [TS_W-1:0]       num,
  input  logic [CFG_DATA_W-1:0] den,
  output logic [TS_W-1:0]       quo,
  output logic [CFG_DATA_W-1:0] rem,
  output logic                  done
);

  localparam int CNT_W = $clog2(TS_W + 1);

  logic                  busy_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [TS_W-1:0]       quo_r;
  logic [CFG_DATA_W-1:0] rem_r;
  logic [CFG_DATA_W-1:0] den_r;
  logic [CFG_DATA_W:0]   trial;
  logic [CFG_DATA_W:0]   diff;
  logic                  ge;

  assign trial = {rem_r, quo_r[TS_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};
  assign done  = busy_r && (cnt_r == CNT_W'(TS_W));
  assign quo   = quo_r;
  assign rem   = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      quo_r  <= num;
      rem_r  <= '0;
      den_r  <= den;
    end else if (busy_r) begin
      if (done) begin
        busy_r <= 1'b0;
      end else begin
        quo_r <= {quo_r[TS_W-2:0], ge};
        rem_r <= ge ? diff[CFG_DATA_W-1:0] : trial[CFG_DATA_W-1:0];
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

endmodule

FILE: design/ictf_isqrt.sv
// ----------------------------------------------------------------------------
// ictf_isqrt
// integer square root of a 48-bit value, two radicand bits per cycle
// ----------------------------------------------------------------------------
module ictf_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] n,
  output logic [23:0] root,
  output logic        done
);

  logic        busy_r;
  logic [47:0] nrem_r;
  logic [47:0] res_r;
  logic [47:0] bitpos_r;
  logic [47:0] trial;

  assign trial = res_r + bitpos_r;
  assign done  = busy_r && (bitpos_r == '0);
  assign root  = res_r[23:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r   <= 1'b1;
      nrem_r   <= n;
      res_r    <= '0;
      bitpos_r <= 48'h1 << 46;
    end else if (busy_r) begin
      if (done) begin
        busy_r <= 1'b0;
      end else begin
        if (nrem_r >= trial) begin
          nrem_r <= nrem_r - trial;
          res_r  <= (res_r >> 1) + bitpos_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bitpos_r <= bitpos_r >> 2;
      end
    end
  end

endmodule

FILE: design/ictf_cordic.sv
// ----------------------------------------------------------------------------
// ictf_cordic
// vectoring cordic atan2(a, b), one rotation per cycle, q3.20 result
// ----------------------------------------------------------------------------
module ictf_cordic import ictf_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [CIN_W-1:0] a_i,
  input  logic signed [CIN_W-1:0] b_i,
  output logic signed [Z_W-1:0]   z_o,
  output logic                    done
);

  localparam int CW = $clog2(CORDIC_STEPS + 1);

  logic                     busy_r;
  logic [CW-1:0]            cnt_r;
  logic signed [CORD_W-1:0] x_r;
  logic signed [CORD_W-1:0] y_r;
  logic signed [Z_W-1:0]    z_r;
  logic signed [CORD_W-1:0] xs;
  logic signed [CORD_W-1:0] ys;
  logic signed [CORD_W-1:0] a_ext;
  logic signed [CORD_W-1:0] b_ext;
  logic signed [Z_W-1:0]    t;

  assign a_ext = CORD_W'(a_i);
  assign b_ext = CORD_W'(b_i);
  assign xs    = x_r >>> cnt_r;
  assign ys    = y_r >>> cnt_r;
  assign t     = atan_entry(6'(cnt_r));
  // stop early once the residual is exactly zero
  assign done  = busy_r && ((y_r == '0) || (cnt_r == CW'(CORDIC_STEPS)));
  assign z_o   = z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      // left half plane: rotate by pi first
      if (b_i < 0) begin
        x_r <= -b_ext;
        y_r <= -a_ext;
        z_r <= (a_i >= 0) ? Z_W'(PI_Q20) : -Z_W'(PI_Q20);
      end else begin
        x_r <= b_ext;
        y_r <= a_ext;
        z_r <= '0;
      end
    end else if (busy_r) begin
      if (done) begin
        busy_r <= 1'b0;
      end else begin
        if (y_r > 0) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + t;
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - t;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

endmodule

FILE: design/imu_complementary_tilt_filter_top.sv
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter_top
// three-axis tilt estimate from gyro and accelerometer transactions
// ----------------------------------------------------------------------------
// in_data carries one sample; func selects gyro or accelerometer. A
// transaction is taken when in_valid is high and in_stall low. Every item
// returns one out_data transaction with the current angles (q3.20).
// The block handles one item at a time and holds in_stall high until its
// result is in the output register.
// Gyro items use the serial divider once for the elapsed ticks and once
// per axis; the first gyro item only records its timestamp. Accel items
// use the 24-step square root and two passes of the cordic unit.
// A finished result waits in the output register while out_stall is high;
// the next item is taken meanwhile, but its result waits for that slot.
// cfg writes (blend weight, ticks per second) are always ready and apply
// to later items. Synchronous reset clears angles and first-sample flags
// and restores the register defaults.
// ----------------------------------------------------------------------------
module imu_complementary_tilt_filter_top import ictf_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int MA_W = 29;
  localparam int MB_W = 27;
  localparam int MP_W = MA_W + MB_W;
  localparam logic [28:0] INC_CAP = 29'd33554432;

  typedef enum logic [15:0] {
    ST_IDLE = 16'h0001,
    ST_GDIV = 16'h0002,
    ST_GMQ  = 16'h0004,
    ST_GMR  = 16'h0008,
    ST_GDS  = 16'h0010,
    ST_GDR  = 16'h0020,
    ST_AM1  = 16'h0040,
    ST_AM2  = 16'h0080,
    ST_AM3  = 16'h0100,
    ST_ASQ  = 16'h0200,
    ST_ACX  = 16'h0400,
    ST_ACZ  = 16'h0800,
    ST_BM1  = 16'h1000,
    ST_BM2  = 16'h2000,
    ST_BM3  = 16'h4000,
    ST_FIN  = 16'h8000
  } state_t;

  state_t                  state_r;
  in_item_t                samp_r;
  logic signed [ANG_W-1:0] ang_r [3];
  logic [CFG_DATA_W-1:0]   blend_r;
  logic [CFG_DATA_W-1:0]   tps_r;
  logic                    gyro_seen_r;
  logic                    accel_seen_r;
  logic [TS_W-1:0]         prev_r;
  logic [25:0]             q_r;
  logic                    qbig_r;
  logic [CFG_DATA_W-1:0]   r_r;
  logic [25:0]             pq_r;
  logic                    pqbig_r;
  logic [1:0]              k_r;
  logic [31:0]             sq_r;
  logic signed [ANG_W-1:0] ax_r;
  logic signed [ANG_W-1:0] az_r;
  logic                    bsel_r;
  logic signed [MP_W-1:0]  p1_r;
  logic signed [MP_W-1:0]  mul_r;
  out_item_t               out_r;
  logic                    out_valid_r;

  logic                    accept;
  logic [CFG_DATA_W-1:0]   tps_eff;
  logic signed [SAMP_W-1:0] rate;
  logic signed [16:0]      rate_ext;
  logic [16:0]             mag17;
  logic [MA_W-1:0]         mag;
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic [16:0]             wc;
  logic signed [ANG_W-1:0] old_ang;
  logic signed [ANG_W-1:0] acc_ang;

  logic                    div_start;
  logic [TS_W-1:0]         div_num;
  logic [TS_W-1:0]         div_quo;
  logic [CFG_DATA_W-1:0]   div_rem;
  logic                    div_done;

  logic                    isq_start;
  logic [47:0]             isq_n;
  logic [23:0]             isq_root;
  logic                    isq_done;

  logic                    cord_start;
  logic signed [CIN_W-1:0] cord_a;
  logic signed [CIN_W-1:0] cord_b;
  logic signed [Z_W-1:0]   cord_z;
  logic                    cord_done;
  logic signed [ANG_W-1:0] cord_sat;

  logic [28:0]             tsum;
  logic [25:0]             tmag;
  logic signed [SAT_W-1:0] inc;
  logic signed [SAT_W-1:0] gsum;
  logic signed [MP_W-1:0]  bsum;
  logic [31:0]             sqsum;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign tps_eff   = (tps_r == '0) ? 16'd1 : tps_r;

  always_comb begin
    case (k_r)
      2'd0:    rate = samp_r.sample_z;
      2'd1:    rate = samp_r.sample_y;
      default: rate = samp_r.sample_x;
    endcase
  end

  assign rate_ext = 17'(rate);
  assign mag17    = rate_ext[16] ? 17'(-rate_ext) : 17'(rate_ext);
  assign mag      = {mag17, 12'b0};
  assign wc       = 17'h10000 - {1'b0, blend_r};
  assign old_ang  = bsel_r ? ang_r[2] : ang_r[0];
  assign acc_ang  = bsel_r ? az_r : ax_r;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_GMQ: begin
        mul_a = signed'(mag);
        mul_b = signed'({1'b0, q_r});
      end
      ST_GMR: begin
        mul_a = signed'(mag);
        mul_b = signed'({11'b0, r_r});
      end
      ST_AM1: begin
        mul_a = MA_W'(samp_r.sample_y);
        mul_b = MB_W'(samp_r.sample_y);
      end
      ST_AM2: begin
        mul_a = MA_W'(samp_r.sample_z);
        mul_b = MB_W'(samp_r.sample_z);
      end
      ST_BM1: begin
        mul_a = MA_W'(old_ang);
        mul_b = signed'({11'b0, blend_r});
      end
      ST_BM2: begin
        mul_a = MA_W'(acc_ang);
        mul_b = signed'({10'b0, wc});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
  end

  assign div_start = (accept && (in_data.func == FUNC_GYRO) && gyro_seen_r)
                     || (state_r == ST_GDS);
  assign div_num   = (state_r == ST_IDLE) ? (in_data.timestamp - prev_r)
                                          : {8'b0, unsigned'(mul_r)};

  ictf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (tps_eff),
    .quo   (div_quo),
    .rem   (div_rem),
    .done  (div_done)
  );

  assign sqsum     = sq_r + mul_r[31:0];
  assign isq_n     = {sqsum, 16'b0};
  assign isq_start = (state_r == ST_AM3);

  ictf_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (isq_start),
    .n     (isq_n),
    .root  (isq_root),
    .done  (isq_done)
  );

  assign cord_start = ((state_r == ST_ASQ) && isq_done) || ((state_r == ST_ACX) && cord_done);
  assign cord_a = (state_r == ST_ASQ) ? CIN_W'(signed'({samp_r.sample_x, 8'b0}))
                                      : CIN_W'(signed'({samp_r.sample_y, 8'b0}));
  assign cord_b = (state_r == ST_ASQ) ? signed'({2'b0, isq_root})
                                      : CIN_W'(signed'({samp_r.sample_z, 8'b0}));

  ictf_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .a_i   (cord_a),
    .b_i   (cord_b),
    .z_o   (cord_z),
    .done  (cord_done)
  );

  assign cord_sat = sat_ang(SAT_W'(cord_z));

  // per-axis increment: mag*q + mag*r/tps, capped
  assign tsum = 29'(pq_r) + 29'(div_quo[27:0]);
  assign tmag = (pqbig_r || (tsum > INC_CAP)) ? INC_CAP[25:0] : tsum[25:0];
  assign inc  = rate[SAMP_W-1] ? -SAT_W'(signed'({1'b0, tmag}))
                               : SAT_W'(signed'({1'b0, tmag}));
  assign gsum = (k_r == 2'd2) ? (SAT_W'(ang_r[k_r]) + inc) : (SAT_W'(ang_r[k_r]) - inc);
  assign bsum = p1_r + mul_r + MP_W'(32768);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      blend_r      <= BLEND_RST;
      tps_r        <= TPS_RST;
      gyro_seen_r  <= 1'b0;
      accel_seen_r <= 1'b0;
      prev_r       <= '0;
      ang_r[0]     <= '0;
      ang_r[1]     <= '0;
      ang_r[2]     <= '0;
      out_valid_r  <= 1'b0;
      k_r          <= '0;
      bsel_r       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_BLEND: blend_r <= cfg_data;
          REG_TPS:   tps_r   <= cfg_data;
        endcase
      end

      // in the final state the output slot is either reloaded or still stalled
      if (out_valid_r && !out_stall && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            samp_r <= in_data;
            if (in_data.func == FUNC_GYRO) begin
              prev_r <= in_data.timestamp;
              if (!gyro_seen_r) begin
                gyro_seen_r <= 1'b1;
                state_r     <= ST_FIN;
              end else begin
                state_r <= ST_GDIV;
              end
            end else begin
              state_r <= ST_AM1;
            end
          end
        end
        ST_GDIV: begin
          if (div_done) begin
            qbig_r  <= (div_quo >= (64'h1 << 26));
            q_r     <= div_quo[25:0];
            r_r     <= div_rem;
            k_r     <= '0;
            state_r <= ST_GMQ;
          end
        end
        ST_GMQ: state_r <= ST_GMR;
        ST_GMR: begin
          // a zero rate never moves the angle, however long the gap
          pqbig_r <= (qbig_r && (mag17 != '0)) || (mul_r > MP_W'(INC_CAP));
          pq_r    <= mul_r[25:0];
          state_r <= ST_GDS;
        end
        ST_GDS: state_r <= ST_GDR;
        ST_GDR: begin
          if (div_done) begin
            ang_r[k_r] <= sat_ang(gsum);
            if (k_r == 2'd2) begin
              state_r <= ST_FIN;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= ST_GMQ;
            end
          end
        end
        ST_AM1: state_r <= ST_AM2;
        ST_AM2: begin
          sq_r    <= mul_r[31:0];
          state_r <= ST_AM3;
        end
        ST_AM3: state_r <= ST_ASQ;
        ST_ASQ: begin
          if (isq_done) begin
            state_r <= ST_ACX;
          end
        end
        ST_ACX: begin
          if (cord_done) begin
            ax_r    <= cord_sat;
            state_r <= ST_ACZ;
          end
        end
        ST_ACZ: begin
          if (cord_done) begin
            if (!accel_seen_r) begin
              accel_seen_r <= 1'b1;
              ang_r[0]     <= ax_r;
              ang_r[1]     <= PI_Q20;
              ang_r[2]     <= cord_sat;
              state_r      <= ST_FIN;
            end else begin
              az_r    <= cord_sat;
              bsel_r  <= 1'b0;
              state_r <= ST_BM1;
            end
          end
        end
        ST_BM1: state_r <= ST_BM2;
        ST_BM2: begin
          p1_r    <= mul_r;
          state_r <= ST_BM3;
        end
        ST_BM3: begin
          if (bsel_r) begin
            ang_r[2] <= sat_ang(SAT_W'(bsum >>> 16));
            state_r  <= ST_FIN;
          end else begin
            ang_r[0] <= sat_ang(SAT_W'(bsum >>> 16));
            bsel_r   <= 1'b1;
            state_r  <= ST_BM1;
          end
        end
        ST_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_r.angle_x <= ang_r[0];
            out_r.angle_y <= ang_r[1];
            out_r.angle_z <= ang_r[2];
            out_valid_r   <= 1'b1;
            state_r       <= ST_IDLE;
          end
        end
      endcase
    end
  end

`include "imu_complementary_tilt_filter_top_assert.svh"

  `ICTF_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall)
  `ICTF_ASSERT_NEXT(a_fin_loads_out, (state_r == ST_FIN) && !out_stall, out_valid)
  `ICTF_ASSERT_NEXT(a_gyro_seen_sticky, gyro_seen_r, gyro_seen_r)
  `ICTF_ASSERT_IMP(a_blend_after_first, state_r == ST_BM1, accel_seen_r)

endmodule

FILE: bench/imu_complementary_tilt_filter_top_test.sv
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter_top_test
// drives gyro and accelerometer transactions through the tilt filter, predicts
// the angles with an independent fixed-point filter model and compares every
// result transaction field by field, under random idling on both sides except in the last random run
// ----------------------------------------------------------------------------
module imu_complementary_tilt_filter_top_test;
  import ictf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  WATCHDOG_LIMIT = 20000;
  localparam int  SETTLE_CYCLES  = 400;
  localparam int  STEPS          = CORDIC_STEPS_DEF;
  localparam longint ANGLE_MAX   = 8388607;
  localparam longint ANGLE_MIN   = -8388608;
  localparam longint PI_FIX      = 3294199;

  localparam longint ARCTAN_FIX [0:19] = '{
    823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192, 4096, 2048,
    1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  imu_complementary_tilt_filter_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // filter state of the predictor
  longint    tilt [3];
  bit        gyro_started;
  bit        accel_started;
  bit [63:0] last_gyro_ticks;
  bit [15:0] weight_reg;
  bit [15:0] tick_rate_reg;

  out_item_t expected_angles [$];
  int        mismatch_count;
  int        sender_idle_pct;
  int        receiver_idle_pct;
  int        quiet_cycles;
  bit [63:0] stim_ticks;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic longint clamp_angle(longint v);
    if (v > ANGLE_MAX) return ANGLE_MAX;
    if (v < ANGLE_MIN) return ANGLE_MIN;
    return v;
  endfunction

  function automatic bit [63:0] root_floor(bit [63:0] n);
    bit [63:0] res;
    bit [63:0] b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint vector_angle(longint a, longint b);
    longint x, y, z, nx, ny;
    x = b;
    y = a;
    z = 0;
    if (b < 0) begin
      x = -b;
      y = -a;
      z = (a >= 0) ? PI_FIX : -PI_FIX;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (y == 0) break;
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z  = z + ARCTAN_FIX[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z  = z - ARCTAN_FIX[i];
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  function automatic longint rate_increment(longint rate, bit [63:0] delta);
    bit [63:0] tps, q, r, mag, t;
    tps = (tick_rate_reg == 0) ? 64'd1 : 64'(tick_rate_reg);
    q   = delta / tps;
    r   = delta % tps;
    mag = 64'((rate < 0) ? -rate : rate) * 64'd4096;
    if (mag == 0) return 0;
    if (q >= 64'd67108864) begin
      t = 64'd33554432;
    end else begin
      t = mag * q + (mag * r) / tps;
      if (t > 64'd33554432) t = 64'd33554432;
    end
    return (rate < 0) ? -longint'(t) : longint'(t);
  endfunction

  function automatic longint blend_angle(longint prev, longint acc);
    longint w;
    w = longint'(weight_reg);
    return clamp_angle((prev * w + acc * (65536 - w) + 32768) >>> 16);
  endfunction

  function automatic out_item_t filter_update(in_item_t it);
    longint    sx, sy, sz, ax, az;
    bit [63:0] delta;
    out_item_t res;
    sx = longint'(it.sample_x);
    sy = longint'(it.sample_y);
    sz = longint'(it.sample_z);
    if (it.func == FUNC_GYRO) begin
      if (!gyro_started) begin
        gyro_started = 1'b1;
        last_gyro_ticks = it.timestamp;
      end else begin
        delta = it.timestamp - last_gyro_ticks;
        last_gyro_ticks = it.timestamp;
        tilt[0] = clamp_angle(tilt[0] - rate_increment(sz, delta));
        tilt[1] = clamp_angle(tilt[1] - rate_increment(sy, delta));
        tilt[2] = clamp_angle(tilt[2] + rate_increment(sx, delta));
      end
    end else begin
      ax = clamp_angle(vector_angle(sx * 256,
             longint'(root_floor(64'(sy * sy + sz * sz) * 64'd65536))));
      az = clamp_angle(vector_angle(sy * 256, sz * 256));
      if (!accel_started) begin
        accel_started = 1'b1;
        tilt[0] = ax;
        tilt[1] = PI_FIX;
        tilt[2] = az;
      end else begin
        tilt[0] = blend_angle(tilt[0], ax);
        tilt[2] = blend_angle(tilt[2], az);
      end
    end
    res.angle_x = tilt[0][23:0];
    res.angle_y = tilt[1][23:0];
    res.angle_z = tilt[2][23:0];
    return res;
  endfunction

  task automatic send_item(in_item_t it);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_angles.push_back(filter_update(it));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    wait (expected_angles.size() == 0);
    @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // both registers back to back, valid dropped once after the second write
  task automatic write_regs(bit [15:0] w, bit [15:0] tps);
    cfg_valid <= 1'b1;
    cfg_index <= REG_BLEND;
    cfg_data  <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    weight_reg = w;
    cfg_index <= REG_TPS;
    cfg_data  <= tps;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tick_rate_reg = tps;
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t make_item(logic f, int x, int y, int z, bit [63:0] ts);
    in_item_t it;
    it.func      = f;
    it.sample_x  = 16'(x);
    it.sample_y  = 16'(y);
    it.sample_z  = 16'(z);
    it.timestamp = ts;
    return it;
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(3))
      0:       return 16'($urandom);
      1:       return 16'(int'($urandom_range(512)) - 256);
      2:       return 16'(int'($urandom_range(4096)) - 2048);
      default: return 16'($urandom_range(1) ? $urandom_range(3) : 0);
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t  it;
    int        pick;
    bit [63:0] span;
    pick = $urandom_range(99);
    it.func     = $urandom_range(1) ? FUNC_ACCEL : FUNC_GYRO;
    it.sample_x = rand_sample();
    it.sample_y = rand_sample();
    it.sample_z = rand_sample();
    span = (tick_rate_reg == 0) ? 64'd4 : 64'(tick_rate_reg) / 8 + 1;
    if (pick < 88) begin
      stim_ticks = stim_ticks + 64'($urandom_range(0, int'(span)));
    end else if (pick < 94) begin
      // backward jump or wide step
      stim_ticks = $urandom_range(1) ? stim_ticks - 64'($urandom_range(1, 1000))
                                     : stim_ticks + 64'($urandom);
    end else begin
      stim_ticks = {$urandom, $urandom};
    end
    it.timestamp = it.func == FUNC_GYRO ? stim_ticks : {$urandom, $urandom};
    return it;
  endfunction

  task automatic test_directed;
    sender_idle_pct = 37;
    receiver_idle_pct = 51;
    send_item(make_item(FUNC_GYRO, 100, -100, 50, 64'd5));
    send_item(make_item(FUNC_GYRO, 32767, -32768, 256, 64'd1005));
    send_item(make_item(FUNC_GYRO, 1, -1, 0, 64'd0));
    send_item(make_item(FUNC_ACCEL, 0, 0, 0, 64'd0));
    send_item(make_item(FUNC_ACCEL, 32767, -32768, -32768, '1));
    send_item(make_item(FUNC_ACCEL, -32768, 0, -1, 64'd0));
    send_item(make_item(FUNC_ACCEL, 0, 0, -256, 64'd0));
    send_item(make_item(FUNC_ACCEL, 256, 32767, 32767, 64'd0));
    send_item(make_item(FUNC_GYRO, 0, 0, 0, '1));
    send_item(make_item(FUNC_GYRO, -32768, 32767, -32768, 64'd0));
    send_item(make_item(FUNC_GYRO, -7, 13, 3, 64'd333));
    drain();
    write_regs(16'd0, 16'd0);
    send_item(make_item(FUNC_GYRO, 3, -2, 1, 64'd334));
    send_item(make_item(FUNC_GYRO, 1, 1, -1, 64'd336));
    send_item(make_item(FUNC_ACCEL, 100, -50, 25, 64'd0));
    drain();
    write_regs(16'd65535, 16'd65535);
    send_item(make_item(FUNC_ACCEL, -32768, -32768, 32767, 64'd0));
    send_item(make_item(FUNC_GYRO, 32767, 32767, 32767, 64'd65871));
    send_item(make_item(FUNC_GYRO, -1, 1, 0, 64'h8000_0000_0000_0000));
    drain();
  endtask

  task automatic test_random(int count, int snd_pct, int rcv_pct, bit [15:0] w,
                             bit [15:0] tps);
    sender_idle_pct = snd_pct;
    receiver_idle_pct = rcv_pct;
    write_regs(w, tps);
    repeat (count) send_item(random_item());
    drain();
  endtask

  // receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= receiver_idle_pct > 0 && $urandom_range(99) < receiver_idle_pct;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_angles.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result transaction %h", out_data);
      end else begin
        want = expected_angles.pop_front();
        if (out_data.angle_x !== want.angle_x || out_data.angle_y !== want.angle_y ||
            out_data.angle_z !== want.angle_z) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("angle mismatch: expected x %0d y %0d z %0d, got x %0d y %0d z %0d",
                     want.angle_x, want.angle_y, want.angle_z,
                     out_data.angle_x, out_data.angle_y, out_data.angle_z);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready) ||
        !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatch_count = 0;
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    stim_ticks = 64'd1000;
    tilt = '{0, 0, 0};
    gyro_started = 1'b0;
    accel_started = 1'b0;
    last_gyro_ticks = 0;
    weight_reg = BLEND_RST;
    tick_rate_reg = TPS_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(230, 37, 51, 16'd64225, 16'd1000);
    test_random(220, 37, 51, 16'd1, 16'd7);
    test_random(230, 51, 37, 16'd32768, 16'd65535);
    test_random(220, 51, 37, 16'd65535, 16'd1);
    test_random(230, 0, 0, 16'($urandom), 16'($urandom_range(1, 65535)));
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_angles.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
